[rtl/ray_triangle_intersect_top_defines.svh]
// Assertion macros used by the top-level RTL
`ifndef RAY_TRIANGLE_INTERSECT_TOP_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_DEFINES_SVH

// same-cycle implication
`define RTI_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rti assertion failed");

// next-cycle implication
`define RTI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rti assertion failed");

`endif

[rtl/rti_pkg.sv]
package rti_pkg;

   // default formats
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // multiplier digit stages: cross products and dot products
   localparam int XMUL_STAGES = 2;
   localparam int DMUL_STAGES = 3;

   // configuration
   localparam int CSR_IDX_W = 3;
   localparam int THR_W     = 32;
   localparam logic [THR_W-1:0] THR_RESET = 32'd281474977;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIG_X,
      REG_ORIG_Y,
      REG_ORIG_Z,
      REG_DIR_X,
      REG_DIR_Y,
      REG_DIR_Z,
      REG_CULL,
      REG_DET_THR
   } rti_reg_type;

   // per-item flags carried alongside the dividers
   typedef struct packed {
      logic hit;
      logic tneg;
      logic ovf;
   } rti_flags_type;

endpackage

[rtl/rti_mul.sv]
module rti_mul import rti_pkg::*; #(
   parameter int WA   = 33,
   parameter int WB   = 33,
   parameter int NSTG = XMUL_STAGES
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [WA-1:0]      a,
   input  logic signed [WB-1:0]      b,
   output logic signed [WA+WB-1:0]   p
);

   localparam int D   = (WB + NSTG - 1) / NSTG;
   localparam int WBX = D * NSTG;
   localparam int WR  = WA + WBX;
   localparam int WPT = WA + D + 1;

   logic signed [WA-1:0]  a_src [NSTG];
   logic signed [WA-1:0]  a_ff  [NSTG];
   logic signed [WBX-1:0] b_src [NSTG];
   logic signed [WBX-1:0] b_ff  [NSTG];
   logic signed [WR-1:0]  acc_src [NSTG];
   logic signed [WR-1:0]  acc_in  [NSTG];
   logic signed [WR-1:0]  acc_ff  [NSTG];
   logic [D-1:0]          dig   [NSTG];
   logic signed [D:0]     dig_s [NSTG];
   logic signed [WPT-1:0] part  [NSTG];

   // one digit of b per stage, top digit signed
   always_comb begin
      a_src[0]   = a;
      b_src[0]   = WBX'(b);
      acc_src[0] = '0;
      for (int k = 1; k < NSTG; k++) begin
         a_src[k]   = a_ff[k-1];
         b_src[k]   = b_ff[k-1];
         acc_src[k] = acc_ff[k-1];
      end
      for (int k = 0; k < NSTG; k++) begin
         dig[k]    = b_src[k][k*D +: D];
         dig_s[k]  = (k == NSTG-1) ? {dig[k][D-1], dig[k]} : {1'b0, dig[k]};
         part[k]   = a_src[k] * dig_s[k];
         acc_in[k] = acc_src[k] + (WR'(part[k]) << (k*D));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NSTG; k++) begin
            a_ff[k]   <= a_src[k];
            b_ff[k]   <= b_src[k];
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   assign p = acc_ff[NSTG-1][WA+WB-1:0];

endmodule

[rtl/rti_div.sv]
module rti_div import rti_pkg::*; #(
   parameter int WD = 102,
   parameter int SH = FRAC_BITS_DEF,
   parameter int QW = COORD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          en,
   input  logic [WD-1:0] num,
   input  logic [WD-1:0] den,
   output logic [QW-1:0] quo
);

   // quotient of (num << SH) / den, one bit per stage, MSB first
   localparam int WX = WD + SH + QW;

   logic [WX-1:0] rem_src [QW];
   logic [WX-1:0] rem_in  [QW];
   logic [WX-1:0] rem_ff  [QW];
   logic [WX-1:0] dsh     [QW];
   logic [WD-1:0] den_src [QW];
   logic [WD-1:0] den_ff  [QW];
   logic [QW-1:0] q_src   [QW];
   logic [QW-1:0] q_in    [QW];
   logic [QW-1:0] q_ff    [QW];
   logic          ge      [QW];

   always_comb begin
      rem_src[0] = WX'(num) << SH;
      den_src[0] = den;
      q_src[0]   = '0;
      for (int k = 1; k < QW; k++) begin
         rem_src[k] = rem_ff[k-1];
         den_src[k] = den_ff[k-1];
         q_src[k]   = q_ff[k-1];
      end
      for (int k = 0; k < QW; k++) begin
         dsh[k]    = WX'(den_src[k]) << (QW-1-k);
         ge[k]     = (rem_src[k] >= dsh[k]);
         rem_in[k] = ge[k] ? (rem_src[k] - dsh[k]) : rem_src[k];
         q_in[k]   = {q_src[k][QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_src[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign quo = q_ff[QW-1];

endmodule

[rtl/rti_geom.sv]
module rti_geom import rti_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] v0   [3],
   input  logic signed [COORD_WIDTH-1:0] v1   [3],
   input  logic signed [COORD_WIDTH-1:0] v2   [3],
   input  logic signed [COORD_WIDTH-1:0] orig [3],
   input  logic signed [COORD_WIDTH-1:0] dir  [3],
   output logic signed [3*COORD_WIDTH+5:0] det,
   output logic signed [3*COORD_WIDTH+5:0] un,
   output logic signed [3*COORD_WIDTH+5:0] vn,
   output logic signed [3*COORD_WIDTH+5:0] tn
);

   localparam int WE = COORD_WIDTH + 1;
   localparam int WX = 2 * WE;
   localparam int WP = WX + 1;
   localparam int WM = WE + WP;
   localparam int WD = 3 * COORD_WIDTH + 6;
   localparam int DL = XMUL_STAGES + 1;

   logic signed [WE-1:0] dir_e [3];
   logic signed [WE-1:0] e1_ff [3];
   logic signed [WE-1:0] e2_ff [3];
   logic signed [WE-1:0] s_ff  [3];
   logic signed [WE-1:0] e1_d_ff [DL][3];
   logic signed [WE-1:0] e2_d_ff [DL][3];
   logic signed [WE-1:0] s_d_ff  [DL][3];
   logic signed [WX-1:0] pa [3];
   logic signed [WX-1:0] pb [3];
   logic signed [WX-1:0] qa [3];
   logic signed [WX-1:0] qb [3];
   logic signed [WP-1:0] p_ff [3];
   logic signed [WP-1:0] q_ff [3];
   logic signed [WM-1:0] det_m [3];
   logic signed [WM-1:0] un_m  [3];
   logic signed [WM-1:0] vn_m  [3];
   logic signed [WM-1:0] tn_m  [3];
   logic signed [WD-1:0] det_ff, un_ff, vn_ff, tn_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) dir_e[i] = WE'(dir[i]);
   end

   // edges and origin offset
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= WE'(v1[i]) - WE'(v0[i]);
            e2_ff[i] <= WE'(v2[i]) - WE'(v0[i]);
            s_ff[i]  <= WE'(orig[i]) - WE'(v0[i]);
         end
      end
   end

   // align edges with the cross products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_d_ff[0][i] <= e1_ff[i];
            e2_d_ff[0][i] <= e2_ff[i];
            s_d_ff[0][i]  <= s_ff[i];
            for (int k = 1; k < DL; k++) begin
               e1_d_ff[k][i] <= e1_d_ff[k-1][i];
               e2_d_ff[k][i] <= e2_d_ff[k-1][i];
               s_d_ff[k][i]  <= s_d_ff[k-1][i];
            end
         end
      end
   end

   // p = dir x e2, q = s x e1
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      rti_mul #(.WA(WE), .WB(WE), .NSTG(XMUL_STAGES)) u_pa (
         .clock(clock), .en(en), .a(dir_e[I1]), .b(e2_ff[I2]), .p(pa[i]));
      rti_mul #(.WA(WE), .WB(WE), .NSTG(XMUL_STAGES)) u_pb (
         .clock(clock), .en(en), .a(dir_e[I2]), .b(e2_ff[I1]), .p(pb[i]));
      rti_mul #(.WA(WE), .WB(WE), .NSTG(XMUL_STAGES)) u_qa (
         .clock(clock), .en(en), .a(s_ff[I1]), .b(e1_ff[I2]), .p(qa[i]));
      rti_mul #(.WA(WE), .WB(WE), .NSTG(XMUL_STAGES)) u_qb (
         .clock(clock), .en(en), .a(s_ff[I2]), .b(e1_ff[I1]), .p(qb[i]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= WP'(pa[i]) - WP'(pb[i]);
            q_ff[i] <= WP'(qa[i]) - WP'(qb[i]);
         end
      end
   end

   // dot product terms
   for (genvar i = 0; i < 3; i++) begin : g_dot
      rti_mul #(.WA(WE), .WB(WP), .NSTG(DMUL_STAGES)) u_det (
         .clock(clock), .en(en), .a(e1_d_ff[DL-1][i]), .b(p_ff[i]), .p(det_m[i]));
      rti_mul #(.WA(WE), .WB(WP), .NSTG(DMUL_STAGES)) u_un (
         .clock(clock), .en(en), .a(s_d_ff[DL-1][i]), .b(p_ff[i]), .p(un_m[i]));
      rti_mul #(.WA(WE), .WB(WP), .NSTG(DMUL_STAGES)) u_vn (
         .clock(clock), .en(en), .a(dir_e[i]), .b(q_ff[i]), .p(vn_m[i]));
      rti_mul #(.WA(WE), .WB(WP), .NSTG(DMUL_STAGES)) u_tn (
         .clock(clock), .en(en), .a(e2_d_ff[DL-1][i]), .b(q_ff[i]), .p(tn_m[i]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= WD'(det_m[0]) + WD'(det_m[1]) + WD'(det_m[2]);
         un_ff  <= WD'(un_m[0]) + WD'(un_m[1]) + WD'(un_m[2]);
         vn_ff  <= WD'(vn_m[0]) + WD'(vn_m[1]) + WD'(vn_m[2]);
         tn_ff  <= WD'(tn_m[0]) + WD'(tn_m[1]) + WD'(tn_m[2]);
      end
   end

   assign det = det_ff;
   assign un  = un_ff;
   assign vn  = vn_ff;
   assign tn  = tn_ff;

endmodule

[rtl/ray_triangle_intersect_top.sv]
// Accepted triangles pass through the digit-serial multipliers of the geometry stage, the
// sign fold, the bounds tests and the one-bit-per-stage restoring dividers.
// Throughput: one triangle per cycle while the skid entry is empty; a two-entry output
// stage (output register and skid) keeps the pipe moving, and a full skid stalls it.
// Reset (synchronous, active high) clears all valid bits and loads the register
// defaults: origin 0, direction (0,0,1.0), no culling, threshold 1e-6.
`include "ray_triangle_intersect_top_defines.svh"

module ray_triangle_intersect_top import rti_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [(COORD_WIDTH > 32 ? COORD_WIDTH : 32)-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_v0_x,
   input  logic signed [COORD_WIDTH-1:0] req_v0_y,
   input  logic signed [COORD_WIDTH-1:0] req_v0_z,
   input  logic signed [COORD_WIDTH-1:0] req_v1_x,
   input  logic signed [COORD_WIDTH-1:0] req_v1_y,
   input  logic signed [COORD_WIDTH-1:0] req_v1_z,
   input  logic signed [COORD_WIDTH-1:0] req_v2_x,
   input  logic signed [COORD_WIDTH-1:0] req_v2_y,
   input  logic signed [COORD_WIDTH-1:0] req_v2_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_t_dist,
   output logic [FRAC_BITS:0]            rsp_u_bary,
   output logic [FRAC_BITS:0]            rsp_v_bary
);

   localparam int C   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int WD  = 3 * C + 6;
   localparam int QW  = (C > F + 1) ? C : F + 1;
   localparam int GL  = XMUL_STAGES + DMUL_STAGES + 3;
   localparam int LAT = GL + 2 + QW;
   localparam int WO  = WD + C + F;
   localparam int RW  = 1 + C + 2 * (F + 1);
   localparam int UVW = F + 2;
   localparam logic [UVW-1:0] UV_ONE = UVW'(1) << F;
   localparam logic [QW-1:0]  T_LIM  = QW'(1) << (C - 1);

   // ---------------- configuration registers ----------------
   logic signed [C-1:0] orig_ff [3];
   logic signed [C-1:0] dir_ff  [3];
   logic                cull_ff;
   logic [THR_W-1:0]    thr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            orig_ff[i] <= '0;
            dir_ff[i]  <= '0;
         end
         dir_ff[2] <= C'(1) << F;
         cull_ff   <= 1'b0;
         thr_ff    <= THR_RESET;
      end else if (csr_valid) begin
         unique case (rti_reg_type'(csr_index))
            REG_ORIG_X:  orig_ff[0] <= csr_wdata[C-1:0];
            REG_ORIG_Y:  orig_ff[1] <= csr_wdata[C-1:0];
            REG_ORIG_Z:  orig_ff[2] <= csr_wdata[C-1:0];
            REG_DIR_X:   dir_ff[0]  <= csr_wdata[C-1:0];
            REG_DIR_Y:   dir_ff[1]  <= csr_wdata[C-1:0];
            REG_DIR_Z:   dir_ff[2]  <= csr_wdata[C-1:0];
            REG_CULL:    cull_ff    <= csr_wdata[0];
            REG_DET_THR: thr_ff     <= csr_wdata[THR_W-1:0];
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic           pipe_en;
   logic [LAT-1:0] valid_ff;
   logic           out_v_ff, out_v_in;
   logic           skid_v_ff, skid_v_in;

   assign pipe_en   = !skid_v_ff;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------- geometry ----------------
   logic signed [C-1:0]  v0_w [3];
   logic signed [C-1:0]  v1_w [3];
   logic signed [C-1:0]  v2_w [3];
   logic signed [WD-1:0] det_w, un_w, vn_w, tn_w;

   assign v0_w[0] = req_v0_x;
   assign v0_w[1] = req_v0_y;
   assign v0_w[2] = req_v0_z;
   assign v1_w[0] = req_v1_x;
   assign v1_w[1] = req_v1_y;
   assign v1_w[2] = req_v1_z;
   assign v2_w[0] = req_v2_x;
   assign v2_w[1] = req_v2_y;
   assign v2_w[2] = req_v2_z;

   rti_geom #(.COORD_WIDTH(C)) u_geom (
      .clock(clock), .en(pipe_en),
      .v0(v0_w), .v1(v1_w), .v2(v2_w), .orig(orig_ff), .dir(dir_ff),
      .det(det_w), .un(un_w), .vn(vn_w), .tn(tn_w));

   // ---------------- sign fold ----------------
   logic signed [WD-1:0] detn_ff, unn_ff, vnn_ff, tnn_ff;
   logic                 cmiss_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cmiss_ff <= det_w[WD-1] & cull_ff;
         detn_ff  <= det_w[WD-1] ? -det_w : det_w;
         unn_ff   <= det_w[WD-1] ? -un_w  : un_w;
         vnn_ff   <= det_w[WD-1] ? -vn_w  : vn_w;
         tnn_ff   <= det_w[WD-1] ? -tn_w  : tn_w;
      end
   end

   // ---------------- bounds tests ----------------
   logic signed [WD:0]  uv_sum;
   logic [WD-1:0]       tmag;
   logic                miss;
   logic                ovf;
   rti_flags_type       fl10_ff;
   logic [WD-1:0]       nu_ff, nv_ff, nt_ff, dd_ff;

   always_comb begin
      uv_sum = (WD+1)'(unn_ff) + (WD+1)'(vnn_ff);
      tmag   = tnn_ff[WD-1] ? $unsigned(-tnn_ff) : $unsigned(tnn_ff);
      miss   = cmiss_ff
            || (detn_ff == '0)
            || ($unsigned(detn_ff) < WD'(thr_ff))
            || unn_ff[WD-1]
            || (unn_ff > detn_ff)
            || vnn_ff[WD-1]
            || (uv_sum > (WD+1)'(detn_ff));
      // quotient would reach 2^C: saturate
      ovf    = ((WO'(tmag) << F) >= (WO'($unsigned(detn_ff)) << C));
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fl10_ff.hit  <= !miss;
         fl10_ff.tneg <= tnn_ff[WD-1];
         fl10_ff.ovf  <= ovf;
         nu_ff        <= $unsigned(unn_ff);
         nv_ff        <= $unsigned(vnn_ff);
         nt_ff        <= tmag;
         dd_ff        <= $unsigned(detn_ff);
      end
   end

   // ---------------- dividers ----------------
   logic [QW-1:0] quo_u, quo_v, quo_t;
   rti_flags_type fl_d_ff [QW];

   rti_div #(.WD(WD), .SH(F), .QW(QW)) u_div_u (
      .clock(clock), .en(pipe_en), .num(nu_ff), .den(dd_ff), .quo(quo_u));
   rti_div #(.WD(WD), .SH(F), .QW(QW)) u_div_v (
      .clock(clock), .en(pipe_en), .num(nv_ff), .den(dd_ff), .quo(quo_v));
   rti_div #(.WD(WD), .SH(F), .QW(QW)) u_div_t (
      .clock(clock), .en(pipe_en), .num(nt_ff), .den(dd_ff), .quo(quo_t));

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fl_d_ff[0] <= fl10_ff;
         for (int k = 1; k < QW; k++) fl_d_ff[k] <= fl_d_ff[k-1];
      end
   end

   // ---------------- result assembly ----------------
   rti_flags_type fl;
   logic [QW-1:0] m_pos, m_neg, t_neg;
   logic [C-1:0]  t_val;
   logic [RW-1:0] res_w;

   always_comb begin
      fl    = fl_d_ff[QW-1];
      m_pos = (fl.ovf || (quo_t > T_LIM - 1'b1)) ? (T_LIM - 1'b1) : quo_t;
      m_neg = (fl.ovf || (quo_t > T_LIM)) ? T_LIM : quo_t;
      t_neg = QW'(0) - m_neg;
      t_val = fl.tneg ? t_neg[C-1:0] : m_pos[C-1:0];
      if (fl.hit) begin
         res_w = {1'b1, t_val, quo_u[F:0], quo_v[F:0]};
      end else begin
         res_w = '0;
      end
   end

   // ---------------- output register and skid ----------------
   logic          push, pop;
   logic          load_out, load_skid, out_from_skid;
   logic [RW-1:0] out_res_ff, skid_res_ff;

   assign push = pipe_en && valid_ff[LAT-1];
   assign pop  = out_v_ff && rsp_ready;

   always_comb begin
      out_v_in      = out_v_ff;
      skid_v_in     = skid_v_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      out_from_skid = 1'b0;
      if (skid_v_ff) begin
         if (pop) begin
            out_from_skid = 1'b1;
            skid_v_in     = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            load_out = 1'b1;
            out_v_in = 1'b1;
         end else begin
            load_skid = 1'b1;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_from_skid) begin
         out_res_ff <= skid_res_ff;
      end else if (load_out) begin
         out_res_ff <= res_w;
      end
      if (load_skid) begin
         skid_res_ff <= res_w;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_hit    = out_res_ff[RW-1];
   assign rsp_t_dist = out_res_ff[RW-2 -: C];
   assign rsp_u_bary = out_res_ff[2*(F+1)-1 -: F+1];
   assign rsp_v_bary = out_res_ff[F:0];

   // ---------------- checks ----------------
   `RTI_ASSERT_IMPL(a_skid_needs_out, clock, reset, skid_v_ff, out_v_ff)
   `RTI_ASSERT_IMPL(a_miss_is_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_t_dist == '0) && (rsp_u_bary == '0) && (rsp_v_bary == '0))
   `RTI_ASSERT_IMPL(a_bary_sum, clock, reset, rsp_valid && rsp_hit, (UVW'(rsp_u_bary) + UVW'(rsp_v_bary)) <= UV_ONE)
   `RTI_ASSERT_NEXT(a_stall_holds, clock, reset, !pipe_en, $stable(valid_ff))

endmodule

[dv/tb_ray_triangle_intersect_top.sv]
`timescale 1ns / 1ps

module tb_ray_triangle_intersect_top;
   import rti_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = XMUL_STAGES + DMUL_STAGES + 5 + CW;
   localparam int Q1 = 65536;

   typedef logic signed [255:0] wide_type;
   typedef logic signed [CW-1:0] coord_type;
   typedef coord_type tri_type [9];

   typedef struct {
      logic          hit;
      logic [CW-1:0] t_dist;
      logic [FB:0]   u_bary;
      logic [FB:0]   v_bary;
   } hit_result_type;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   coord_type req_v0_x, req_v0_y, req_v0_z;
   coord_type req_v1_x, req_v1_y, req_v1_z;
   coord_type req_v2_x, req_v2_y, req_v2_z;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_hit;
   logic signed [CW-1:0] rsp_t_dist;
   logic [FB:0] rsp_u_bary;
   logic [FB:0] rsp_v_bary;

   // shadow of the ray registers
   coord_type ray_org [3];
   coord_type ray_dir [3];
   logic cull_on;
   logic [THR_W-1:0] det_thr;

   hit_result_type pending_hits [$];
   int fail_count;
   int tris_sent;
   int results_seen;
   int hits_seen;
   int cfg_writes;
   bit gaps_on;
   bit stall_on;
   bit hold_req;

   ray_triangle_intersect_top dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_v0_x(req_v0_x), .req_v0_y(req_v0_y), .req_v0_z(req_v0_z),
      .req_v1_x(req_v1_x), .req_v1_y(req_v1_y), .req_v1_z(req_v1_z),
      .req_v2_x(req_v2_x), .req_v2_y(req_v2_y), .req_v2_z(req_v2_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_t_dist(rsp_t_dist),
      .rsp_u_bary(rsp_u_bary), .rsp_v_bary(rsp_v_bary)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void cross3(input wide_type a [3], input wide_type b [3],
                                  output wide_type r [3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic wide_type dot3(input wide_type a [3], input wide_type b [3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   // exact Moller-Trumbore on wide integers
   function automatic hit_result_type intersect_predict(input tri_type tr);
      wide_type v0 [3], e1 [3], e2 [3], s [3], p [3], q [3], o [3], d [3];
      wide_type det, un, vn, tn, mag, qt;
      logic tneg;
      hit_result_type r;
      int i;
      r.hit = 1'b0;
      r.t_dist = '0;
      r.u_bary = '0;
      r.v_bary = '0;
      for (i = 0; i < 3; i++) begin
         v0[i] = wide_type'(tr[i]);
         e1[i] = wide_type'(tr[3+i]) - v0[i];
         e2[i] = wide_type'(tr[6+i]) - v0[i];
         o[i]  = wide_type'(ray_org[i]);
         d[i]  = wide_type'(ray_dir[i]);
         s[i]  = o[i] - v0[i];
      end
      cross3(d, e2, p);
      det = dot3(e1, p);
      un = dot3(s, p);
      cross3(s, e1, q);
      vn = dot3(d, q);
      tn = dot3(e2, q);
      // back face: reject when culling, else fold signs relative to det
      if (det < 0) begin
         if (cull_on) return r;
         det = -det;
         un = -un;
         vn = -vn;
         tn = -tn;
      end
      if (det == 0 || det < wide_type'({224'd0, det_thr})) return r;
      if (un < 0 || un > det || vn < 0 || un + vn > det) return r;
      r.hit = 1'b1;
      qt = (un <<< FB) / det;
      r.u_bary = qt[FB:0];
      qt = (vn <<< FB) / det;
      r.v_bary = qt[FB:0];
      tneg = tn < 0;
      mag = tneg ? -tn : tn;
      mag = (mag <<< FB) / det;
      // saturate distance
      if (!tneg)
         r.t_dist = (mag > wide_type'(64'sh7FFFFFFF)) ? 32'h7FFFFFFF : mag[CW-1:0];
      else
         r.t_dist = (mag > wide_type'(64'sh80000000)) ? 32'h80000000 : -mag[CW-1:0];
      return r;
   endfunction

   function automatic int gap_len();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 0;
      if (sel < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // send one triangle; expectation is formed at acceptance
   task automatic send_tri(input tri_type tr);
      int g;
      g = gaps_on ? gap_len() : 0;
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_v0_x <= tr[0]; req_v0_y <= tr[1]; req_v0_z <= tr[2];
      req_v1_x <= tr[3]; req_v1_y <= tr[4]; req_v1_z <= tr[5];
      req_v2_x <= tr[6]; req_v2_y <= tr[7]; req_v2_z <= tr[8];
      do @(posedge clock); while (!req_ready);
      pending_hits.push_back(intersect_predict(tr));
      tris_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      stop_sending();
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic csr_write(input rti_reg_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx) inside
         REG_ORIG_X, REG_ORIG_Y, REG_ORIG_Z: ray_org[idx - REG_ORIG_X] = data;
         REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[idx - REG_DIR_X] = data;
         REG_CULL: cull_on = data[0];
         default: det_thr = data;
      endcase
      cfg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_ray(input coord_type ox, oy, oz, dx, dy, dz, input logic cull,
                          input logic [31:0] thr);
      csr_write(REG_ORIG_X, ox);
      csr_write(REG_ORIG_Y, oy);
      csr_write(REG_ORIG_Z, oz);
      csr_write(REG_DIR_X, dx);
      csr_write(REG_DIR_Y, dy);
      csr_write(REG_DIR_Z, dz);
      csr_write(REG_CULL, {31'd0, cull});
      csr_write(REG_DET_THR, thr);
   endtask

   function automatic tri_type mk_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
      tri_type tr;
      tr = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
      return tr;
   endfunction

   function automatic coord_type rnd_small(input int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // triangle built around a point on the ray, mostly hitting
   function automatic tri_type aimed_tri();
      tri_type tr;
      int k, a, b, i;
      logic signed [63:0] pt, e1, e2;
      k = $urandom_range(8);
      a = $urandom_range(255);
      b = $urandom_range(255 - a);
      for (i = 0; i < 3; i++) begin
         pt = 64'(ray_org[i]) + 64'(ray_dir[i]) * 64'(k) + 64'(rnd_small(512));
         e1 = 64'(rnd_small(1 << 18));
         e2 = 64'(rnd_small(1 << 18));
         tr[i] = coord_type'(pt - ((e1 * 64'(a) + e2 * 64'(b)) >>> 8));
         tr[3+i] = coord_type'(64'(tr[i]) + e1);
         tr[6+i] = coord_type'(64'(tr[i]) + e2);
      end
      return tr;
   endfunction

   // mostly aimed, some raw noise and broken (flattened or perturbed) triangles
   function automatic tri_type rand_tri();
      tri_type tr;
      int sel, i;
      sel = $urandom_range(99);
      tr = aimed_tri();
      if (sel < 15) begin
         for (i = 0; i < 9; i++) tr[i] = $urandom;
      end else if (sel < 22) begin
         for (i = 0; i < 3; i++) tr[6+i] = tr[3+i];
      end else if (sel < 30) begin
         i = $urandom_range(8);
         tr[i] = tr[i] ^ (32'h1 << $urandom_range(31));
      end
      return tr;
   endfunction

   task automatic send_random(input int n);
      repeat (n) send_tri(rand_tri());
   endtask

   // ---- tests ----

   task automatic test_directed();
      gaps_on = 0;
      send_tri(mk_tri(-Q1, -Q1, 5 * Q1, 2 * Q1, -Q1, 5 * Q1, -Q1, 2 * Q1, 5 * Q1));
      // opposite winding, positive determinant
      send_tri(mk_tri(-Q1, -Q1, 5 * Q1, -Q1, 2 * Q1, 5 * Q1, 2 * Q1, -Q1, 5 * Q1));
      // behind the origin
      send_tri(mk_tri(-Q1, -Q1, -5 * Q1, 2 * Q1, -Q1, -5 * Q1, -Q1, 2 * Q1, -5 * Q1));
      // ray through a vertex and through an edge
      send_tri(mk_tri(0, 0, Q1, 3 * Q1, 0, Q1, 0, 3 * Q1, Q1));
      send_tri(mk_tri(-Q1, 0, Q1, Q1, 0, Q1, 0, Q1, Q1));
      // parallel plane: zero determinant
      send_tri(mk_tri(-Q1, 0, 0, Q1, 0, 0, 0, 0, Q1));
      // collinear vertices
      send_tri(mk_tri(0, 0, 0, Q1, Q1, Q1, 2 * Q1, 2 * Q1, 2 * Q1));
      // off to the side
      send_tri(mk_tri(4 * Q1, 4 * Q1, Q1, 6 * Q1, 4 * Q1, Q1, 4 * Q1, 6 * Q1, Q1));
      // tiny triangle, determinant under threshold
      send_tri(mk_tri(-1, -1, Q1, 2, -1, Q1, -1, 2, Q1));
      // coordinate extremes
      send_tri(mk_tri(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      send_tri(mk_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
      send_tri(mk_tri(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
      send_tri(mk_tri(32'h80000000, 32'h80000000, 5 * Q1, 32'h7FFFFFFF, 32'h80000000,
                      5 * Q1, 32'h80000000, 32'h7FFFFFFF, 5 * Q1));
      send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_tri(mk_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
      wait_drained();
   endtask

   task automatic test_random_default();
      gaps_on = 1;
      stall_on = 1;
      send_random(250);
      wait_drained();
   endtask

   task automatic test_config_sweep();
      int k;
      // culling on, threshold zero, negative-facing triangles miss
      set_ray(0, 0, 0, 0, 0, Q1, 1'b1, 32'd0);
      send_tri(mk_tri(-Q1, -Q1, 5 * Q1, -Q1, 2 * Q1, 5 * Q1, 2 * Q1, -Q1, 5 * Q1));
      send_tri(mk_tri(-Q1, -Q1, 5 * Q1, 2 * Q1, -Q1, 5 * Q1, -Q1, 2 * Q1, 5 * Q1));
      send_tri(mk_tri(-Q1, 0, 0, Q1, 0, 0, 0, 0, Q1));
      send_random(80);
      wait_drained();
      // maximum threshold: only large determinants pass
      set_ray(0, 0, 0, 0, 0, Q1, 1'b0, 32'hFFFFFFFF);
      send_random(80);
      wait_drained();
      // extreme origin and direction values
      set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 1'b0, 32'd1);
      send_random(40);
      wait_drained();
      // random rays, alternating culling
      for (k = 0; k < 4; k++) begin
         set_ray(rnd_small(1 << 20), rnd_small(1 << 20), rnd_small(1 << 20),
                 rnd_small(1 << 17), rnd_small(1 << 17), rnd_small(1 << 17),
                 k[0], $urandom_range(1 << 30));
         send_random(70);
         wait_drained();
      end
   endtask

   task automatic test_saturation();
      // tiny direction makes the distance overflow in both signs
      set_ray(0, 0, 0, 0, 0, 1, 1'b0, 32'd0);
      send_tri(mk_tri(-Q1, -Q1, 100 * Q1, 2 * Q1, -Q1, 100 * Q1, -Q1, 2 * Q1, 100 * Q1));
      send_tri(mk_tri(-Q1, -Q1, -100 * Q1, 2 * Q1, -Q1, -100 * Q1, -Q1, 2 * Q1, -100 * Q1));
      send_random(40);
      wait_drained();
   endtask

   task automatic test_backpressure();
      set_ray(rnd_small(1 << 18), rnd_small(1 << 18), 0, rnd_small(1 << 16),
              rnd_small(1 << 16), Q1, 1'b0, THR_RESET);
      gaps_on = 0;
      @(negedge clock);
      hold_req = 1;
      send_random(150);
      gaps_on = 1;
      send_random(60);
      // pause until everything has come back, then carry on
      wait_drained();
      send_random(60);
      stall_on = 0;
      gaps_on = 0;
      send_random(100);
      wait_drained();
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_ready <= (stall_on && gap_len() > 0) ? 1'b0 : 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      hit_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_hits.size() == 0) begin
            $error("result with no triangle outstanding");
            fail_count++;
         end else begin
            exp_r = pending_hits.pop_front();
            if (rsp_hit) hits_seen++;
            if (rsp_hit !== exp_r.hit) begin
               $error("hit: expected %0b actual %0b", exp_r.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_t_dist !== exp_r.t_dist) begin
               $error("t_dist: expected %h actual %h", exp_r.t_dist, rsp_t_dist);
               fail_count++;
            end
            if (rsp_u_bary !== exp_r.u_bary) begin
               $error("u_bary: expected %h actual %h", exp_r.u_bary, rsp_u_bary);
               fail_count++;
            end
            if (rsp_v_bary !== exp_r.v_bary) begin
               $error("v_bary: expected %h actual %h", exp_r.v_bary, rsp_v_bary);
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("ray_triangle_intersect_top verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      {req_v0_x, req_v0_y, req_v0_z} = '0;
      {req_v1_x, req_v1_y, req_v1_z} = '0;
      {req_v2_x, req_v2_y, req_v2_z} = '0;
      ray_org = '{0, 0, 0};
      ray_dir = '{0, 0, Q1};
      cull_on = 1'b0;
      det_thr = THR_RESET;
      fail_count = 0;
      tris_sent = 0;
      results_seen = 0;
      hits_seen = 0;
      cfg_writes = 0;
      gaps_on = 0;
      stall_on = 0;
      hold_req = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (LATENCY + 8) @(posedge clock);

      test_directed();
      test_random_default();
      test_config_sweep();
      test_saturation();
      test_backpressure();

      if (pending_hits.size() != 0) begin
         $error("%0d results never arrived", pending_hits.size());
         fail_count++;
      end
      $display("covered %0d triangles, %0d results (%0d hits), %0d register writes",
               tris_sent, results_seen, hits_seen, cfg_writes);
      $display("culling, thresholds, saturation, back-pressure and drain pauses exercised");
      if (fail_count == 0)
         $display("ray_triangle_intersect_top verification clean");
      else
         $display("ray_triangle_intersect_top verification failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/rti_pkg.sv
rtl/rti_mul.sv
rtl/rti_div.sv
rtl/rti_geom.sv
rtl/ray_triangle_intersect_top.sv
dv/tb_ray_triangle_intersect_top.sv
